@@ src/slfd_pkg.sv @@
// Shared constants and types for the sync/length frame deframer.
package slfd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned LenW  = 16;

	localparam logic [ByteW-1:0] SYNC_FIRST  = 8'hAA;
	localparam logic [ByteW-1:0] SYNC_SECOND = 8'h55;

	localparam logic [LenW-1:0] MAX_PAYLOAD_RESET = 16'd1020;

	// Parser phase, one-hot
	typedef enum logic [4:0] {
		PH_HUNT    = 5'b00001,
		PH_SEEN_AA = 5'b00010,
		PH_LEN_HI  = 5'b00100,
		PH_LEN_LO  = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	// One step result from the parser
	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] data;
		logic             first;
		logic             last;
	} result_t;

endpackage

@@ src/slfd_parser.sv @@
// Frame parser: sync hunt, length capture and payload count, one byte per step.
module slfd_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [slfd_pkg::ByteW-1:0]   byte_in,
	input  logic [slfd_pkg::LenW-1:0]    max_payload,
	output slfd_pkg::result_t            result
);

	slfd_pkg::phase_t phase_q, phase_d;
	logic [slfd_pkg::ByteW-1:0] len_hi_q, len_hi_d;
	logic [slfd_pkg::LenW-1:0]  left_q, left_d;
	logic                       first_q, first_d;

	logic [slfd_pkg::LenW-1:0] len;
	logic                      len_bad;
	logic                      last;
	slfd_pkg::phase_t          scan_phase;

	assign len        = {len_hi_q, byte_in};
	assign len_bad    = (len == '0) || (len > max_payload);
	assign last       = (left_q <= slfd_pkg::LenW'(1));
	assign scan_phase = (byte_in == slfd_pkg::SYNC_FIRST) ? slfd_pkg::PH_SEEN_AA
	                                                      : slfd_pkg::PH_HUNT;

	always_comb begin
		phase_d      = phase_q;
		len_hi_d     = len_hi_q;
		left_d       = left_q;
		first_d      = first_q;
		result.valid = 1'b0;
		result.data  = byte_in;
		result.first = first_q;
		result.last  = last;
		unique case (phase_q)
			slfd_pkg::PH_SEEN_AA: begin
				phase_d = (byte_in == slfd_pkg::SYNC_SECOND) ? slfd_pkg::PH_LEN_HI
				                                             : scan_phase;
			end
			slfd_pkg::PH_LEN_HI: begin
				len_hi_d = byte_in;
				phase_d  = slfd_pkg::PH_LEN_LO;
			end
			slfd_pkg::PH_LEN_LO: begin
				if (len_bad) begin
					// rescan the two length bytes as a possible sync pair
					if (len_hi_q == slfd_pkg::SYNC_FIRST && byte_in == slfd_pkg::SYNC_SECOND) begin
						phase_d = slfd_pkg::PH_LEN_HI;
					end else begin
						phase_d = scan_phase;
					end
				end else begin
					left_d  = len;
					first_d = 1'b1;
					phase_d = slfd_pkg::PH_PAYLOAD;
				end
			end
			slfd_pkg::PH_PAYLOAD: begin
				result.valid = 1'b1;
				first_d      = 1'b0;
				if (last) begin
					left_d  = '0;
					phase_d = slfd_pkg::PH_HUNT;
				end else begin
					left_d = left_q - slfd_pkg::LenW'(1);
				end
			end
			default: begin
				phase_d = scan_phase;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= slfd_pkg::PH_HUNT;
			len_hi_q <= '0;
			left_q   <= '0;
			first_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			len_hi_q <= len_hi_d;
			left_q   <= left_d;
			first_q  <= first_d;
		end
	end

endmodule

@@ src/sync_length_frame_deframer.sv @@
// Top level of the sync-word, length-prefixed frame deframer.
// Takes one received byte per item and hunts for the sync pair AA 55, then
// reads a big-endian 16-bit payload length and passes on that many payload
// bytes, marking the first and last byte of each frame. A header whose
// length is zero or above max_payload is dropped and its two length bytes
// are rescanned as a possible new sync start. Throughput is one byte per
// cycle while the output is not stalled; a payload byte goes from the input
// register through the parser step into the result register, which drives
// the output. The result register is the only place a stall from downstream
// can hold work: in_stall rises only when a payload byte sits in the input
// register while the result register is full and stalled. Header and sync
// bytes give no item out and never wait on the output side. max_payload
// resets to 1020 and is written with cfg_wr_en/cfg_wr_data; the user must
// write it only while the block is idle, which the block does not enforce;
// a new value applies from the next header.
module sync_length_frame_deframer (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_wr_en,
	input  logic [slfd_pkg::LenW-1:0]  cfg_wr_data,
	// received bytes
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [slfd_pkg::ByteW-1:0] in_byte,
	// payload bytes
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [slfd_pkg::ByteW-1:0] payload_byte,
	output logic                       frame_first,
	output logic                       frame_last
);

	logic [slfd_pkg::LenW-1:0]  max_payload_q;

	// input register
	logic                       valid_s1;
	logic [slfd_pkg::ByteW-1:0] byte_s1;

	// result register
	logic                       valid_s2;
	logic [slfd_pkg::ByteW-1:0] byte_s2;
	logic                       first_s2;
	logic                       last_s2;

	slfd_pkg::result_t          res;
	logic                       out_free;
	logic                       adv_s1;
	logic                       take_in;

	// Result register can take a new item when empty or being drained.
	assign out_free = !valid_s2 || !out_stall;
	// The byte in s1 moves on unless it makes an item with nowhere to go.
	assign adv_s1   = valid_s1 && (!res.valid || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= slfd_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_wr_en) begin
			max_payload_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= in_byte;
		end
	end

	slfd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.byte_in     (byte_s1),
		.max_payload (max_payload_q),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv_s1 && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res.valid) begin
			byte_s2  <= res.data;
			first_s2 <= res.first;
			last_s2  <= res.last;
		end
	end

	assign out_valid    = valid_s2;
	assign payload_byte = byte_s2;
	assign frame_first  = first_s2;
	assign frame_last   = last_s2;

	// Input may only be held back by a full, stalled result register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("in_stall without a blocked result register");

	// A new item never overwrites one that is still waiting downstream.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && res.valid) |-> (!valid_s2 || !out_stall))
		else $error("result register overwritten while stalled");

	// A stalled byte in s1 stays and keeps the parser frozen.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a stalled byte");

endmodule
